[hdl/md5sh_pkg.sv]
package md5sh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic put_byte;     // write in_byte at fill position
    logic put_pad;      // write the 0x80 mark and clear the rest of the block
    logic clear_block;  // zero all block words
    logic put_len;      // write the bit length to words 14 and 15
    logic start_round;  // load working registers from chain
    logic do_round;     // perform one round
    logic fold;         // add working registers into chain
    logic restart;      // return chain, fill and length to initial values
  } md5sh_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       block_full;  // fill wrapped to zero after a write of byte 63
    logic       last_round;
  } md5sh_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[hdl/md5sh_datapath.sv]
module md5sh_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  md5sh_pkg::md5sh_cmd_t  cmd,
  input  logic [7:0]             in_byte,
  output md5sh_pkg::md5sh_stat_t stat,
  output logic [127:0]           digest
);

  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic        wrapped;
  logic [63:0] msg_bits;
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;

  logic [31:0] f, sum, rot;
  logic [3:0]  g;
  logic [5:0]  g5, g3, g7;

  always_comb begin
    g5 = 6'({rnd, 2'b00} + rnd + 6'd1);
    g3 = 6'({rnd, 1'b0} + rnd + 6'd5);
    g7 = 6'({rnd, 3'b000} - rnd);
    unique case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (b & d) | (c & ~d); g = g5[3:0]; end
      2'd2: begin f = b ^ c ^ d;          g = g3[3:0]; end
      default: begin f = c ^ (b | ~d);    g = g7[3:0]; end
    endcase
    sum = a + f + blk[g] + md5sh_pkg::round_k(rnd);
    rot = (sum << md5sh_pkg::round_s(rnd)) | (sum >> (6'd32 - {1'b0, md5sh_pkg::round_s(rnd)}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= md5sh_pkg::IV_A;
      chain[1] <= md5sh_pkg::IV_B;
      chain[2] <= md5sh_pkg::IV_C;
      chain[3] <= md5sh_pkg::IV_D;
      fill <= '0;
      wrapped <= 1'b0;
      msg_bits <= '0;
      rnd <= '0;
    end else begin
      wrapped <= 1'b0;
      if (cmd.put_byte) begin
        for (int i = 0; i < 4; i++)
          if (fill[1:0] == 2'(i)) blk[fill[5:2]][8*i +: 8] <= in_byte;
        fill <= fill + 6'd1;
        wrapped <= (fill == 6'd63);
        msg_bits <= msg_bits + 64'd8;
      end
      if (cmd.put_pad) begin
        for (int w = 0; w < 16; w++)
          for (int i = 0; i < 4; i++)
            if ({4'(w), 2'(i)} == fill) blk[w][8*i +: 8] <= md5sh_pkg::PAD_MARK;
            else if ({4'(w), 2'(i)} > fill) blk[w][8*i +: 8] <= 8'h00;
      end
      if (cmd.clear_block)
        for (int w = 0; w < 16; w++) blk[w] <= '0;
      if (cmd.put_len) begin
        blk[14] <= msg_bits[31:0];
        blk[15] <= msg_bits[63:32];
      end
      if (cmd.start_round) begin
        a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
        rnd <= '0;
      end
      if (cmd.do_round) begin
        a <= d; d <= c; c <= b; b <= b + rot;
        rnd <= rnd + 6'd1;
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
      end
      if (cmd.restart) begin
        chain[0] <= md5sh_pkg::IV_A;
        chain[1] <= md5sh_pkg::IV_B;
        chain[2] <= md5sh_pkg::IV_C;
        chain[3] <= md5sh_pkg::IV_D;
        fill <= '0;
        msg_bits <= '0;
      end
    end
  end

  assign stat.fill = fill;
  assign stat.block_full = wrapped;
  assign stat.last_round = (rnd == 6'd63);
  assign digest = {md5sh_pkg::bswap(chain[0]), md5sh_pkg::bswap(chain[1]),
                   md5sh_pkg::bswap(chain[2]), md5sh_pkg::bswap(chain[3])};

endmodule

[hdl/md5sh_ctrl.sv]
module md5sh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  logic                   in_has_byte,
  input  logic                   in_last,
  input  md5sh_pkg::md5sh_stat_t stat,
  input  logic                   out_taken,
  output md5sh_pkg::md5sh_cmd_t  cmd,
  output logic                   in_ready,
  output logic                   out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PAD, S_LEN, S_START, S_ROUND, S_FOLD, S_EXTRA, S_OUT
  } state_t;

  state_t state;
  logic   finishing;  // current compression belongs to the message end
  logic   final_blk;  // block in flight carries the length
  logic   pend_last;

  always_comb begin
    cmd = '0;
    cmd.put_byte = in_fire && in_has_byte;
    unique case (state)
      S_PAD:   cmd.put_pad = 1'b1;
      S_EXTRA: cmd.clear_block = 1'b1;
      S_LEN:   cmd.put_len = 1'b1;
      S_START: cmd.start_round = 1'b1;
      S_ROUND: cmd.do_round = 1'b1;
      S_FOLD:  cmd.fold = 1'b1;
      S_OUT:   cmd.restart = out_taken;
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire && (in_has_byte || in_last)) begin
          pend_last <= in_last;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.block_full) begin
            finishing <= 1'b0;
            final_blk <= 1'b0;
            state <= S_START;
          end else if (pend_last) state <= S_PAD;
          else state <= S_IDLE;
        end
        S_PAD: begin
          finishing <= 1'b1;
          if (stat.fill >= 6'd56) begin
            final_blk <= 1'b0;
            state <= S_START;
          end else begin
            final_blk <= 1'b1;
            state <= S_LEN;
          end
        end
        S_EXTRA: begin
          final_blk <= 1'b1;
          state <= S_LEN;
        end
        S_LEN:   state <= S_START;
        S_START: state <= S_ROUND;
        S_ROUND: if (stat.last_round) state <= S_FOLD;
        S_FOLD: begin
          if (!finishing) state <= pend_last ? S_PAD : S_IDLE;
          else if (final_blk) state <= S_OUT;
          else state <= S_EXTRA;
        end
        S_OUT: if (out_taken) begin
          finishing <= 1'b0;
          pend_last <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/md5_stream_hasher.sv]
// MD5 hashing of a byte stream.
// Input channel s_axis: one word per message byte. tdata carries the byte,
// tuser[0] says whether the byte belongs to the message, and tlast ends the
// message; a word may carry tlast with no byte, so the empty message works.
// Output channel m_axis: one word per message, tdata[63:0] holds digest
// bytes 0..7 and tdata[127:64] bytes 8..15, lower byte index more
// significant within each half.
// Flow: a byte word is taken and then checked in the following cycle, and
// no new word is taken during the check or a compression. Every 64th byte
// starts a compression (load, 64 rounds, fold) on a single round unit.
// At the end of a message padding is added, then one or two compressions
// run: a second one when the end word also fills a block or when the length
// needs a block of its own. m_axis_tvalid rises once the final fold is done.
// The digest is held on m_axis until taken.
// While the receiver stalls, s_axis_tready stays low. After the digest is
// taken the chaining values, byte count and length return to their initial
// values. Reset (rst, synchronous) brings the block to the same start state.
module md5_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // has_byte
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_high, digest_low
);

  md5sh_pkg::md5sh_cmd_t  cmd;
  md5sh_pkg::md5sh_stat_t stat;
  logic [127:0]           digest;
  logic                   in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  md5sh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_has_byte(s_axis_tuser),
    .in_last(s_axis_tlast), .stat(stat), .out_taken(m_axis_tvalid && m_axis_tready),
    .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  md5sh_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_byte(s_axis_tdata),
    .stat(stat), .digest(digest)
  );

  // digest_high in the low half, digest_low in the upper half.
  assign m_axis_tdata = {digest[63:0], digest[127:64]};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while digest pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !($countones({cmd.put_pad, cmd.do_round, cmd.fold, cmd.restart}) > 1))
    else $error("datapath commands overlap");
`endif

endmodule

[bench/tb_top.sv]
module tb_top;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // data_byte
  logic         s_axis_tuser;   // has_byte
  logic         s_axis_tlast;   // last
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // digest_high, digest_low

  md5_stream_hasher dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Clock with a period of 8 time units.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // One stimulus word: the byte, whether it belongs to the message, and the
  // end flag. Rows of the directed table may carry a known digest.
  typedef struct {
    logic [7:0]   data_byte;
    logic         has_byte;
    logic         last;
    logic         known;
    logic [127:0] digest;
  } stim_row_t;

  // Our own copy of the hasher state.
  logic [31:0] chain [4];
  logic [31:0] block [16];
  int unsigned fill;
  logic [63:0] msg_bits;

  // Digests that the block still owes us, oldest first.
  logic [127:0] pending_digests [$];

  int unsigned fail_count;
  int unsigned digests_seen;
  int unsigned words_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        recv_hold;

  // Per-round additive constants and rotate amounts, written out here so the
  // predictor does not lean on the package helpers.
  logic [31:0] kconst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  int unsigned rot_by [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                               4, 11, 16, 23, 6, 10, 15, 21};

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] byte_swap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  task automatic start_message();
    chain[0] = md5sh_pkg::IV_A;
    chain[1] = md5sh_pkg::IV_B;
    chain[2] = md5sh_pkg::IV_C;
    chain[3] = md5sh_pkg::IV_D;
    fill = 0;
    msg_bits = '0;
  endtask

  // Fold the current block into the chaining words.
  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, st;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int unsigned i = 0; i < 64; i++) begin
      st = i / 16;
      case (st)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl(a + f + block[g] + kconst[i], rot_by[st * 4 + i % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic put_byte(int unsigned pos, logic [7:0] v);
    block[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  // Advance the predicted hasher by one accepted word; returns 1 and the
  // digest when the word ends the message.
  task automatic hash_word(input logic [7:0] data_byte, input logic has_byte,
                           input logic last, output logic emit,
                           output logic [127:0] digest);
    int unsigned tail;
    emit = 1'b0;
    digest = '0;
    if (has_byte) begin
      put_byte(fill, data_byte);
      msg_bits += 64'd8;
      fill++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (!last) return;
    tail = fill;
    put_byte(tail, md5sh_pkg::PAD_MARK);
    for (int unsigned p = tail + 1; p < 64; p++) put_byte(p, 8'h00);
    // Fewer than eight bytes left after the mark: the length needs a block
    // of its own.
    if (tail >= 56) begin
      compress_block();
      for (int w = 0; w < 16; w++) block[w] = '0;
    end
    block[14] = msg_bits[31:0];
    block[15] = msg_bits[63:32];
    compress_block();
    digest = {byte_swap(chain[0]), byte_swap(chain[1]),
              byte_swap(chain[2]), byte_swap(chain[3])};
    emit = 1'b1;
    start_message();
  endtask

  // Offer one word to the block and wait until it is taken, then predict.
  // tvalid stays high from one word to the next unless the sender idles.
  task automatic send_word(input stim_row_t row);
    logic         emit;
    logic [127:0] dg;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.data_byte;
    s_axis_tuser  <= row.has_byte;
    s_axis_tlast  <= row.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    hash_word(row.data_byte, row.has_byte, row.last, emit, dg);
    if (emit) begin
      if (row.known && dg !== row.digest) begin
        $error("predictor digest: expected %h, actual %h", row.digest, dg);
        fail_count++;
      end
      pending_digests.push_back(dg);
    end
  endtask

  task automatic send_bytes(input int unsigned n, input logic end_it);
    stim_row_t row;
    for (int unsigned i = 0; i < n; i++) begin
      row = '{data_byte: 8'($urandom), has_byte: 1'b1,
              last: end_it && (i == n - 1), known: 1'b0, digest: '0};
      send_word(row);
    end
  endtask

  // Receiver: random stalls, plus a long hold while recv_hold is set.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every taken digest against the oldest one predicted.
  // digest_high sits in the low half of tdata, digest_low in the upper half.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_digests.size() == 0) begin
        $error("digest: none expected, actual %h", m_axis_tdata);
        fail_count++;
      end else begin
        logic [127:0] want;
        want = pending_digests.pop_front();
        if (m_axis_tdata[63:0] !== want[127:64]) begin
          $error("digest_high: expected %h, actual %h", want[127:64],
                 m_axis_tdata[63:0]);
          fail_count++;
        end
        if (m_axis_tdata[127:64] !== want[63:0]) begin
          $error("digest_low: expected %h, actual %h", want[63:0],
                 m_axis_tdata[127:64]);
          fail_count++;
        end
      end
      digests_seen++;
    end
  end

  // Long receiver stall, counted in cycles, during the padding-edge messages
  // while the sender keeps offering words.
  initial begin
    recv_hold = 1'b0;
    wait (words_sent >= 40);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
  end

  // Watchdog.
  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    int unsigned len, kind, wait_cycles;
    int unsigned pad_lens [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    fail_count = 0;
    digests_seen = 0;
    words_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    start_message();
    for (int w = 0; w < 16; w++) block[w] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Known digests: the empty message, "a" and "abc".
    rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e});
    rows.push_back('{8'h61, 1'b1, 1'b1, 1'b1, 128'h0cc175b9c0f1b6a831c399e269772661});
    rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'hff, 1'b0, 1'b0, 1'b0, '0});  // no byte, no end: ignored
    rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 128'h900150983cd24fb0d6963f7d28e17f72});
    rows.push_back('{8'hff, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h55, 1'b0, 1'b1, 1'b0, '0});  // end with no byte
    rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i]);

    // Padding boundaries: lengths around 55/56/64 and a multi-block message.
    foreach (pad_lens[i]) send_bytes(pad_lens[i], 1'b1);
    r = '{8'h00, 1'b0, 1'b1, 1'b0, '0};
    send_bytes(64, 1'b0);
    send_word(r);

    // Random messages under three idling profiles.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 25 : 0;
      for (int unsigned n = 0; n < 330;) begin
        kind = $urandom_range(9);
        if (kind == 0) begin
          // Noise: words with no byte, some ending the message.
          r = '{8'($urandom), 1'b0, 1'($urandom), 1'b0, '0};
          send_word(r);
        end else begin
          len = (kind < 8) ? $urandom_range(70) : $urandom_range(130);
          send_bytes(len, 1'b0);
          r = '{8'($urandom), 1'($urandom), 1'b1, 1'b0, '0};
          send_word(r);
          n += len + 1;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_digests.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (pending_digests.size() != 0) begin
      $error("digest: %0d expected digests never arrived", pending_digests.size());
      fail_count++;
    end

    $display("Hashed %0d words into %0d digests, covering empty messages,",
             words_sent, digests_seen);
    $display("padding edges, multi-block messages, stalls and a long back-pressure.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/md5sh_pkg.sv
hdl/md5sh_datapath.sv
hdl/md5sh_ctrl.sv
hdl/md5_stream_hasher.sv
bench/tb_top.sv
